// ----- rtl/core/tcwc_pkg.sv -----
// Shared constants and types for the TCP congestion window controller.
`timescale 1ns / 1ps

package tcwc_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned MSS_W    = 16;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned PEER_W   = 16;
	localparam int unsigned DUP_W    = 2;
	localparam int unsigned PADDR_W  = 4;
	localparam int unsigned PDATA_W  = 32;
	localparam int unsigned DIV_STEPS = WORD_W;
	localparam int unsigned STEP_W   = $clog2(DIV_STEPS);

	localparam logic [MODE_W-1:0] MODE_ACK     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_START   = 2'd2;

	localparam logic [DUP_W-1:0] DUP_LIMIT = 2'd3;

	typedef enum logic [1:0] {
		REG_MSS        = 2'd0,
		REG_INIT_WIN   = 2'd1,
		REG_INIT_THR   = 2'd2,
		REG_INIT_ACK   = 2'd3
	} reg_idx_t;

	localparam logic [MSS_W-1:0]  RST_MSS      = 16'd1400;
	localparam logic [WORD_W-1:0] RST_INIT_WIN = 32'd4200;
	localparam logic [WORD_W-1:0] RST_INIT_THR = 32'd8192;
	localparam logic [WORD_W-1:0] RST_INIT_ACK = 32'd0;

endpackage

// ----- rtl/core/tcp_congestion_window_control_top.sv -----
// Congestion window controller: APB registers, window state and radix-2 serial divider.
//
//   channel  | handshake                         | payload
//   ---------+-----------------------------------+-------------------------------------------
//   item     | item_valid / item_ready           | mode, ack_value, peer_window
//   result   | result_valid / result_ready       | congestion_window, slow_start_threshold,
//            |                                   | retransmit, zero_window
//   config   | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// Every item but a congestion-avoidance ack goes from exec straight to emit; such an ack
// passes multiply, an add and, between them, the 32-step one-bit-per-cycle divider
// that forms mss*mss/window. One item is in work at a time; the result register holds the
// previous item so a new item is taken while that result waits. A held result stalls only
// the final write of the next item's result. Reset clears window, threshold, last ack and
// duplicate count to zero and loads the register defaults.
`timescale 1ns / 1ps

module tcp_congestion_window_control_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tcwc_pkg::PADDR_W-1:0]      paddr,
	input  logic [tcwc_pkg::PDATA_W-1:0]      pwdata,
	output logic [tcwc_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [tcwc_pkg::MODE_W-1:0]       mode,
	input  logic [tcwc_pkg::WORD_W-1:0]       ack_value,
	input  logic [tcwc_pkg::PEER_W-1:0]       peer_window,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [tcwc_pkg::WORD_W-1:0]       congestion_window,
	output logic [tcwc_pkg::WORD_W-1:0]       slow_start_threshold,
	output logic                              retransmit,
	output logic                              zero_window
);
	import tcwc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_ADD,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [MSS_W-1:0]  mss_q;
	logic [WORD_W-1:0] init_win_q;
	logic [WORD_W-1:0] init_thr_q;
	logic [WORD_W-1:0] init_ack_q;

	logic [WORD_W-1:0] win_q;
	logic [WORD_W-1:0] thr_q;
	logic [WORD_W-1:0] last_ack_q;
	logic [DUP_W-1:0]  dup_q;

	logic [MODE_W-1:0] mode_q;
	logic [WORD_W-1:0] ack_q;
	logic [PEER_W-1:0] peer_q;
	logic              rt_q;
	logic              zw_q;

	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;

	logic              res_valid_q;
	logic [WORD_W-1:0] res_win_q;
	logic [WORD_W-1:0] res_thr_q;
	logic              res_rt_q;
	logic              res_zw_q;

	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	logic [WORD_W-1:0] half_win;
	logic [WORD_W-1:0] mss_word;
	logic [WORD_W:0]   grow_sum;
	logic [WORD_W-1:0] grow_add;
	logic [WORD_W-1:0] grow_sat;
	logic [DUP_W-1:0]  dup_inc;
	logic [WORD_W-1:0] sq;
	logic [WORD_W:0]   rem_shift;
	logic              trial_ge;
	logic [WORD_W:0]   rem_diff;

	logic [WORD_W-1:0] x_win;
	logic [WORD_W-1:0] x_thr;
	logic [WORD_W-1:0] x_last;
	logic [DUP_W-1:0]  x_dup;
	logic              x_rt;
	logic              x_zw;
	logic              x_div;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		case (cfg_idx)
			REG_MSS:      prdata = {{(PDATA_W-MSS_W){1'b0}}, mss_q};
			REG_INIT_WIN: prdata = init_win_q;
			REG_INIT_THR: prdata = init_thr_q;
			REG_INIT_ACK: prdata = init_ack_q;
			default:      prdata = '0;
		endcase
	end

	assign item_ready = (state_q == ST_IDLE);

	assign result_valid         = res_valid_q;
	assign congestion_window    = res_win_q;
	assign slow_start_threshold = res_thr_q;
	assign retransmit           = res_rt_q;
	assign zero_window          = res_zw_q;

	assign half_win = win_q >> 1;
	assign mss_word = {{(WORD_W-MSS_W){1'b0}}, mss_q};
	assign dup_inc  = dup_q + 1'b1;

	// One adder serves slow-start growth and the avoidance step after the divide.
	assign grow_add = (state_q == ST_ADD) ? quo_q : mss_word;
	assign grow_sum = {1'b0, win_q} + {1'b0, grow_add};
	assign grow_sat = grow_sum[WORD_W] ? '1 : grow_sum[WORD_W-1:0];

	assign sq = mss_word * mss_word;

	// Restoring divide: shift in one dividend bit per cycle, quotient bits shift in behind.
	assign rem_shift = {rem_q, quo_q[WORD_W-1]};
	assign rem_diff  = rem_shift - {1'b0, win_q};
	assign trial_ge  = (rem_shift >= {1'b0, win_q});

	always_comb begin
		x_win  = win_q;
		x_thr  = thr_q;
		x_last = last_ack_q;
		x_dup  = dup_q;
		x_rt   = 1'b0;
		x_zw   = 1'b0;
		x_div  = 1'b0;
		case (mode_q)
			MODE_START: begin
				x_win  = init_win_q;
				x_thr  = init_thr_q;
				x_last = init_ack_q;
				x_dup  = '0;
			end
			MODE_TIMEOUT: begin
				x_thr = half_win;
				x_win = (mss_word < half_win) ? mss_word : half_win;
				x_rt  = 1'b1;
			end
			MODE_ACK: begin
				x_last = ack_q;
				if (peer_q == '0) begin
					x_zw = 1'b1;
					x_rt = 1'b1;
				end else if (ack_q == last_ack_q) begin
					if (dup_inc == DUP_LIMIT) begin
						x_thr = half_win;
						x_win = half_win + 1'b1;
						x_dup = '0;
						x_rt  = 1'b1;
					end else begin
						x_dup = dup_inc;
					end
				end else begin
					x_dup = '0;
					if (win_q <= thr_q) begin
						x_win = grow_sat;
					end else begin
						x_div = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mss_q       <= RST_MSS;
			init_win_q  <= RST_INIT_WIN;
			init_thr_q  <= RST_INIT_THR;
			init_ack_q  <= RST_INIT_ACK;
			win_q       <= '0;
			thr_q       <= '0;
			last_ack_q  <= '0;
			dup_q       <= '0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					REG_MSS:      mss_q      <= pwdata[MSS_W-1:0];
					REG_INIT_WIN: init_win_q <= pwdata;
					REG_INIT_THR: init_thr_q <= pwdata;
					REG_INIT_ACK: init_ack_q <= pwdata;
					default: begin
					end
				endcase
			end

			// the emit step reloads the result register itself
			if (res_valid_q && result_ready && (state_q != ST_EMIT)) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						mode_q  <= mode;
						ack_q   <= ack_value;
						peer_q  <= peer_window;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					win_q      <= x_win;
					thr_q      <= x_thr;
					last_ack_q <= x_last;
					dup_q      <= x_dup;
					rt_q       <= x_rt;
					zw_q       <= x_zw;
					state_q    <= x_div ? ST_MUL : ST_EMIT;
				end
				ST_MUL: begin
					quo_q   <= sq;
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= trial_ge ? rem_diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
					quo_q  <= {quo_q[WORD_W-2:0], trial_ge};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					win_q   <= grow_sat;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// hold until the result register is free
					if (!res_valid_q || result_ready) begin
						res_valid_q <= 1'b1;
						res_win_q   <= win_q;
						res_thr_q   <= thr_q;
						res_rt_q    <= rt_q;
						res_zw_q    <= zw_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIV) |-> (step_q == '0) || ($past(state_q) == ST_DIV))
		else $error("divider step count left running outside the divide");

	a_dup_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		dup_q != DUP_LIMIT)
		else $error("duplicate count reached the limit without a halving");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside the emit step");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("second item taken while one is in work");
`endif

endmodule
